>>> hw/rtl/pmpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmpg_pkg;

    localparam int PATCH_CELLS_DEF = 8;
    localparam int MAX_GHOST_DEF   = 1;

    // request kinds
    localparam logic [1:0] REQ_LOAD     = 2'd0;
    localparam logic [1:0] REQ_PARTICLE = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;

    // interpolation kinds
    localparam logic [1:0] SCHEME_NGP = 2'd0;
    localparam logic [1:0] SCHEME_CIC = 2'd1;
    localparam logic [1:0] SCHEME_TSC = 2'd2;

    // energy coefficient kinds
    localparam logic [1:0] COEFF_HALF = 2'd1;
    localparam logic [1:0] COEFF_ONE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_INTERP_SCHEME = 2'd0;
    localparam logic [1:0] REG_GHOST_WIDTH   = 2'd1;
    localparam logic [1:0] REG_INV_CELL      = 2'd2;
    localparam logic [1:0] REG_COEFF_MODE    = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         cell_index;
        logic signed [31:0] pot_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] edge_x;
        logic signed [31:0] edge_y;
        logic signed [31:0] edge_z;
        logic [31:0]        particle_mass;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] contribution;
        logic signed [63:0] energy_total;
        logic               saturated;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/particle_mesh_potential_gather.sv
// particle mesh potential gather
// input channel (in_valid / in_stall / in_item): load items write one potential
// cell of the patch grid, clear items zero the running total and its clip flag,
// particle items gather potential around the particle and return one result.
// output channel (out_valid / out_stall / out_item): one item per particle with
// its energy term, the running total after it and the sticky clip flag.
// configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write it only while the block is idle.
// load and clear items never stall the input. a particle item holds in_stall
// high through the axis steps (AXM, AXT, for TSC also AXQ0 to AXQ2), steps C1
// to C4 per gathered cell (1, 8 or 27 cells) and the final scaling and
// accumulation; an invalid scheme or coefficient mode skips to accumulating a
// zero term. one shared 34x34 multiplier and one grid read port set the pace.
// the result sits in an output register; while out_stall is high it holds and
// a following particle waits at its final step, load and clear items go when idle.
// reset (rst_n low, asynchronous) clears the total, the clip flag and the
// sequencer and restores the register defaults; grid contents are undefined
// until loaded.
`timescale 1ns / 1ps
`default_nettype none

module particle_mesh_potential_gather
    import pmpg_pkg::*;
#(
    parameter int PATCH_CELLS = PATCH_CELLS_DEF,
    parameter int MAX_GHOST   = MAX_GHOST_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int SIDE_MAX = PATCH_CELLS + 2 * MAX_GHOST;
    localparam int DEPTH    = SIDE_MAX * SIDE_MAX * SIDE_MAX;
    localparam int AW       = $clog2(DEPTH);
    localparam int SW       = $clog2(SIDE_MAX + 1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_AXM  = 5'd1;
    localparam logic [4:0] ST_AXT  = 5'd2;
    localparam logic [4:0] ST_AXQ0 = 5'd3;
    localparam logic [4:0] ST_AXQ1 = 5'd4;
    localparam logic [4:0] ST_AXQ2 = 5'd5;
    localparam logic [4:0] ST_C1   = 5'd6;
    localparam logic [4:0] ST_C2   = 5'd7;
    localparam logic [4:0] ST_C3   = 5'd8;
    localparam logic [4:0] ST_C4   = 5'd9;
    localparam logic [4:0] ST_MAG  = 5'd10;
    localparam logic [4:0] ST_FH   = 5'd11;
    localparam logic [4:0] ST_FL   = 5'd12;
    localparam logic [4:0] ST_FR   = 5'd13;
    localparam logic [4:0] ST_FS   = 5'd14;
    localparam logic [4:0] ST_FT   = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // configuration
    logic [1:0]  scheme_reg;
    logic        ghost_reg;
    logic [31:0] icw_reg;
    logic [1:0]  coeff_reg;

    // control
    logic [4:0]  state_reg, state_next;
    logic [1:0]  ax_reg;
    logic [1:0]  ci_reg, cj_reg, ck_reg;
    logic        out_valid_reg;

    // running total
    logic signed [63:0] total_reg;
    logic               clip_reg;

    // datapath
    in_item_t           item_reg;
    logic signed [67:0] prod_reg;
    logic [15:0]        f_reg;
    logic [30:0]        w_reg [3][3];
    logic [SW-1:0]      b_reg [3];
    logic signed [63:0] acc_reg;
    logic               neg_reg;
    logic [63:0]        mag_reg;
    logic [63:0]        hi_reg;
    logic [63:0]        res_reg;
    logic signed [63:0] contrib_reg;
    logic [31:0]        rd_data_reg;
    out_item_t          out_reg;

    logic [31:0] grid_mem [DEPTH];

    logic g_eff;
    logic [SW-1:0] side;
    assign g_eff = (MAX_GHOST > 0) ? ghost_reg : 1'b0;
    assign side  = SW'(PATCH_CELLS) + (g_eff ? SW'(2) : SW'(0));

    logic [1:0] ncell;
    always_comb
    begin
        case (scheme_reg)
            SCHEME_NGP: ncell = 2'd1;
            SCHEME_CIC: ncell = 2'd2;
            default:    ncell = 2'd3;
        endcase
    end

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    assign mp = ma * mb;

    logic signed [32:0] d_axis;
    always_comb
    begin
        case (ax_reg)
            2'd0:    d_axis = 33'(item_reg.pos_x) - 33'(item_reg.edge_x);
            2'd1:    d_axis = 33'(item_reg.pos_y) - 33'(item_reg.edge_y);
            default: d_axis = 33'(item_reg.pos_z) - 33'(item_reg.edge_z);
        endcase
    end

    logic [49:0] p_val;
    assign p_val = mag_reg[63:14];

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_AXM:
            begin
                ma = 34'(d_axis);
                mb = $signed({2'b00, icw_reg});
            end
            ST_AXQ0:
            begin
                ma = $signed(34'(17'h10000 - {1'b0, f_reg}));
                mb = $signed(34'(17'h10000 - {1'b0, f_reg}));
            end
            ST_AXQ1:
            begin
                ma = $signed({18'd0, f_reg});
                mb = $signed({18'd0, f_reg});
            end
            ST_C1:
            begin
                ma = $signed({3'd0, w_reg[0][ci_reg]});
                mb = $signed({3'd0, w_reg[1][cj_reg]});
            end
            ST_C2:
            begin
                ma = $signed({3'd0, prod_reg[60:30]});
                mb = $signed({3'd0, w_reg[2][ck_reg]});
            end
            ST_C3:
            begin
                ma = $signed({3'd0, prod_reg[60:30]});
                mb = 34'($signed(rd_data_reg));
            end
            ST_FH:
            begin
                ma = $signed({2'b00, item_reg.particle_mass});
                mb = $signed({16'd0, p_val[49:32]});
            end
            ST_FL:
            begin
                ma = $signed({2'b00, item_reg.particle_mass});
                mb = $signed({2'b00, p_val[31:0]});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // axis position to base index and fraction
    logic signed [52:0] t_val, t_shift;
    logic signed [36:0] ip;
    logic signed [36:0] side_s;
    logic [SW-1:0]      base_val;
    always_comb
    begin
        case (scheme_reg)
            SCHEME_CIC: t_shift = g_eff ? 53'sd32768 : -53'sd32768;
            SCHEME_TSC: t_shift = g_eff ? 53'sd65536 : 53'sd0;
            default:    t_shift = 53'sd0;
        endcase
        t_val  = $signed({prod_reg[67], prod_reg[67:16]}) + t_shift;
        ip     = t_val[52:16];
        side_s = $signed({{(37 - SW){1'b0}}, side});
        case (scheme_reg)
            SCHEME_NGP:
            begin
                if (ip[36])
                    base_val = '0;
                else if (ip > side_s - 37'sd1)
                    base_val = side - SW'(1);
                else
                    base_val = SW'(ip);
            end
            SCHEME_CIC:
            begin
                if (ip[36])
                    base_val = '0;
                else if (ip + 37'sd1 >= side_s)
                    base_val = side - SW'(2);
                else
                    base_val = SW'(ip);
            end
            default:
            begin
                if (ip < 37'sd1)
                    base_val = '0;
                else if (ip + 37'sd1 >= side_s)
                    base_val = side - SW'(3);
                else
                    base_val = SW'(ip - 37'sd1);
            end
        endcase
    end

    // grid address of the current cell
    logic [SW-1:0] xc, yc, zc;
    logic [AW-1:0] cell_addr;
    assign xc = b_reg[0] + SW'(ci_reg);
    assign yc = b_reg[1] + SW'(cj_reg);
    assign zc = b_reg[2] + SW'(ck_reg);
    assign cell_addr = AW'((32'(zc) * 32'(side) + 32'(yc)) * 32'(side) + 32'(xc));

    logic        load_ok;
    logic [AW-1:0] load_addr;
    assign load_ok   = 32'(in_item.cell_index) < 32'(DEPTH);
    assign load_addr = AW'(in_item.cell_index);

    logic active;
    assign active = (scheme_reg <= SCHEME_TSC) &&
                    ((coeff_reg == COEFF_HALF) || (coeff_reg == COEFF_ONE));

    logic last_cell;
    assign last_cell = (ci_reg == ncell - 2'd1) && (cj_reg == ncell - 2'd1) &&
                       (ck_reg == ncell - 2'd1);

    // final scaling terms
    logic [63:0]        res_val;
    logic [63:0]        sat_val;
    logic signed [63:0] sum_val;
    logic               ovf;
    always_comb
    begin
        if (coeff_reg == COEFF_HALF)
            res_val = (hi_reg << 15) + (prod_reg[63:0] >> 17);
        else
            res_val = (hi_reg << 16) + (prod_reg[63:0] >> 16);
        sat_val = res_reg;
        if (!neg_reg && res_reg[63])
            sat_val = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (neg_reg && res_reg > 64'h8000_0000_0000_0000)
            sat_val = 64'h8000_0000_0000_0000;
        sum_val = total_reg + contrib_reg;
        ovf = (total_reg[63] == contrib_reg[63]) && (sum_val[63] != contrib_reg[63]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept_in && in_item.req_type == REQ_PARTICLE)
                    state_next = active ? ST_AXM : ST_FT;
            ST_AXM:  state_next = ST_AXT;
            ST_AXT:
                if (scheme_reg == SCHEME_TSC)
                    state_next = ST_AXQ0;
                else if (ax_reg == 2'd2)
                    state_next = ST_C1;
                else
                    state_next = ST_AXM;
            ST_AXQ0: state_next = ST_AXQ1;
            ST_AXQ1: state_next = ST_AXQ2;
            ST_AXQ2: state_next = (ax_reg == 2'd2) ? ST_C1 : ST_AXM;
            ST_C1:   state_next = ST_C2;
            ST_C2:   state_next = ST_C3;
            ST_C3:   state_next = ST_C4;
            ST_C4:   state_next = last_cell ? ST_MAG : ST_C1;
            ST_MAG:  state_next = ST_FH;
            ST_FH:   state_next = ST_FL;
            ST_FL:   state_next = ST_FR;
            ST_FR:   state_next = ST_FS;
            ST_FS:   state_next = ST_FT;
            ST_FT:   state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_reg        <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            scheme_reg    <= SCHEME_CIC;
            ghost_reg     <= 1'b1;
            icw_reg       <= 32'h0001_0000;
            coeff_reg     <= COEFF_HALF;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INTERP_SCHEME: scheme_reg <= cfg_data[1:0];
                    REG_GHOST_WIDTH:   ghost_reg  <= cfg_data[0];
                    REG_INV_CELL:      icw_reg    <= cfg_data;
                    REG_COEFF_MODE:    coeff_reg  <= cfg_data[1:0];
                    default:           scheme_reg <= scheme_reg;
                endcase
            end
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    ax_reg <= '0;
                    if (accept_in && in_item.req_type == REQ_CLEAR)
                    begin
                        total_reg <= '0;
                        clip_reg  <= 1'b0;
                    end
                end
                ST_AXT:
                    if (scheme_reg != SCHEME_TSC)
                        ax_reg <= ax_reg + 2'd1;
                ST_AXQ2:
                    ax_reg <= ax_reg + 2'd1;
                ST_C4:
                begin
                    if (ci_reg == ncell - 2'd1)
                    begin
                        ci_reg <= '0;
                        if (cj_reg == ncell - 2'd1)
                        begin
                            cj_reg <= '0;
                            if (ck_reg == ncell - 2'd1)
                                ck_reg <= '0;
                            else
                                ck_reg <= ck_reg + 2'd1;
                        end
                        else
                            cj_reg <= cj_reg + 2'd1;
                    end
                    else
                        ci_reg <= ci_reg + 2'd1;
                end
                ST_FT:
                begin
                    if (ovf)
                    begin
                        total_reg <= contrib_reg[63] ? $signed(64'h8000_0000_0000_0000)
                                                     : $signed(64'h7FFF_FFFF_FFFF_FFFF);
                        clip_reg  <= 1'b1;
                    end
                    else
                        total_reg <= sum_val;
                end
                default:
                    ax_reg <= ax_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mp;
        case (state_reg)
            ST_IDLE:
                if (accept_in)
                begin
                    item_reg    <= in_item;
                    acc_reg     <= '0;
                    contrib_reg <= '0;
                end
            ST_AXT:
            begin
                f_reg         <= t_val[15:0];
                b_reg[ax_reg] <= base_val;
                if (scheme_reg == SCHEME_NGP)
                    w_reg[ax_reg][0] <= ONE_Q30;
                else
                begin
                    w_reg[ax_reg][0] <= 31'(17'h10000 - {1'b0, t_val[15:0]}) << 14;
                    w_reg[ax_reg][1] <= 31'(t_val[15:0]) << 14;
                end
            end
            ST_AXQ1:
                w_reg[ax_reg][0] <= 31'(prod_reg[63:3]);
            ST_AXQ2:
            begin
                w_reg[ax_reg][2] <= 31'(prod_reg[63:3]);
                w_reg[ax_reg][1] <= ONE_Q30 - w_reg[ax_reg][0] - 31'(prod_reg[63:3]);
            end
            ST_C1:
                rd_data_reg <= grid_mem[cell_addr];
            ST_C4:
                acc_reg <= acc_reg + prod_reg[63:0];
            ST_MAG:
            begin
                neg_reg <= acc_reg[63];
                mag_reg <= acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
            end
            ST_FL:
                hi_reg <= prod_reg[63:0];
            ST_FR:
                res_reg <= res_val;
            ST_FS:
                contrib_reg <= neg_reg ? $signed(-sat_val) : $signed(sat_val);
            ST_OUT:
                if (!out_valid_reg || !out_stall)
                begin
                    out_reg.contribution <= contrib_reg;
                    out_reg.energy_total <= total_reg;
                    out_reg.saturated    <= clip_reg;
                end
            default:
                f_reg <= f_reg;
        endcase
    end

    // grid memory write port
    always_ff @(posedge clk)
    begin
        if (accept_in && in_item.req_type == REQ_LOAD && load_ok)
            grid_mem[load_addr] <= in_item.pot_value;
    end

endmodule

`default_nettype wire

>>> hw/rtl/pmpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pmpg_checker
    import pmpg_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_item,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // a particle item keeps the block busy afterward
    a_particle_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.req_type == REQ_PARTICLE |=> in_stall)
        else $error("block took a new item right after a particle");

    // a result only appears after a busy period
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a particle in flight");

    // load and clear items never block the input
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.req_type == REQ_LOAD ||
        in_item.req_type == REQ_CLEAR) |=> !in_stall)
        else $error("load or clear item stalled the input");

endmodule

bind particle_mesh_potential_gather pmpg_checker u_pmpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
